/* src/rlsc_pkg.sv */
// Shared types and constants for the rectangle layout sanity classifier.
// Holds the stored rectangle record, status codes and FSM states.
// No dependencies.
`default_nettype none
package rlsc_pkg;

  typedef enum logic [2:0] {
    ST_SANE      = 3'd0,
    ST_ENCLOSED  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_OVERLAP   = 3'd3,
    ST_OFFSCREEN = 3'd4,
    ST_DISABLED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [3:0]         scr;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] w;
    logic signed [31:0] h;
    logic signed [32:0] r;
    logic signed [32:0] b;
  } rect_t;

  typedef struct packed {
    status_t    st;
    logic [5:0] enemy;
  } stat_t;

  typedef struct packed {
    logic same_scr;
    logic encl;
    logic dup;
    logic ovl;
  } cmp_t;

  typedef enum logic [2:0] {
    FSM_LOAD,
    FSM_RD_OUTER,
    FSM_LATCH,
    FSM_INNER,
    FSM_NEXT_OUTER,
    FSM_EMIT_RD,
    FSM_EMIT_WAIT
  } fsm_t;

  localparam logic signed [32:0] EDGE_LIMIT = 33'sh7FFF;

endpackage
`default_nettype wire

/* src/rlsc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module rlsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/rlsc_eval.sv */
// Pair comparator: screen match, enclosure, identity and overlap tests of two rectangles.
// Depends on rlsc_pkg.
`default_nettype none
module rlsc_eval (
  input  wire rlsc_pkg::rect_t outer,
  input  wire rlsc_pkg::rect_t inner,
  output rlsc_pkg::cmp_t       cmp
);

  logic signed [31:0] ml;
  logic signed [31:0] mt;
  logic signed [33:0] ml1;
  logic signed [33:0] mt1;

  always_comb begin
    ml  = (outer.x > inner.x) ? outer.x : inner.x;
    mt  = (outer.y > inner.y) ? outer.y : inner.y;
    ml1 = 34'(ml) + 34'sd1;
    mt1 = 34'(mt) + 34'sd1;
    cmp.same_scr = (outer.scr == inner.scr);
    cmp.encl = (inner.x >= outer.x) && (inner.y >= outer.y) &&
               (inner.r <= outer.r) && (inner.b <= outer.b);
    cmp.dup = (outer.x == inner.x) && (outer.y == inner.y) &&
              (outer.w == inner.w) && (outer.h == inner.h);
    cmp.ovl = (ml1 < 34'(outer.r)) && (34'(ml) < 34'(inner.r)) &&
              (mt1 < 34'(outer.b)) && (34'(mt) < 34'(inner.b));
  end

endmodule
`default_nettype wire

/* src/rectangle_layout_sanity_classifier_core.sv */
// Rectangles load back to back while in_stall is low. Classifying n rectangles is
// paced by the single read port shared by the rectangle and status RAMs, which the
// pairwise loops visit one entry at a time. Results are then emitted in index order.
// The input is stalled from the last rectangle until the final result is registered.
// Synchronous reset clears the FSM, counters and output valid; RAM contents are kept.
`default_nettype none
module rectangle_layout_sanity_classifier_core #(
  parameter int MAX_RECTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         screen_tag,
  input  wire logic signed [31:0] left,
  input  wire logic signed [31:0] top,
  input  wire logic signed [31:0] span_x,
  input  wire logic signed [31:0] span_y,
  input  wire logic               disabled_in,
  input  wire logic               last_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              rect_index,
  output logic [2:0]              status,
  output logic [5:0]              enemy_index,
  output logic                    last_out
);

  localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CW = $clog2(MAX_RECTS + 1);

  rlsc_pkg::fsm_t    state, state_next;
  logic              pass2;
  logic [IW-1:0]     i, j;
  logic [CW-1:0]     count;
  rlsc_pkg::rect_t   outer;
  rlsc_pkg::status_t outer_st;
  logic [IW-1:0]     outer_en;
  logic              ovl_hit;

  rlsc_pkg::rect_t   rrect, wrect;
  rlsc_pkg::stat_t   rstat, wstat;
  logic [IW-1:0]     raddr, waddr_stat;
  logic              we_rect, we_stat;
  rlsc_pkg::cmp_t    cmp;

  logic              load_acc, has_room, inner_last, outer_last, emit_take;
  logic              p1_hit, p2_hit, offscr;
  logic [CW-1:0]     limit;

  assign in_stall  = (state != rlsc_pkg::FSM_LOAD);
  assign load_acc  = in_valid && !in_stall;
  assign has_room  = (count < CW'(MAX_RECTS));
  assign limit     = pass2 ? CW'(i) : count;
  assign inner_last = ((CW + 1)'(j) + (CW + 1)'(1)) == (CW + 1)'(limit);
  assign outer_last = ((CW + 1)'(i) + (CW + 1)'(1)) == (CW + 1)'(count);
  assign emit_take = (state == rlsc_pkg::FSM_EMIT_WAIT) && (!out_valid || !out_stall);

  always_comb begin
    wrect.scr = screen_tag;
    wrect.x   = left;
    wrect.y   = top;
    wrect.w   = span_x;
    wrect.h   = span_y;
    wrect.r   = 33'(left) + 33'(span_x);
    wrect.b   = 33'(top) + 33'(span_y);
  end

  rlsc_ram #(.WIDTH($bits(rlsc_pkg::rect_t)), .DEPTH(MAX_RECTS)) u_rect_ram (
    .clk(clk), .we(we_rect), .waddr(count[IW-1:0]), .wdata(wrect),
    .raddr(raddr), .rdata(rrect)
  );

  rlsc_ram #(.WIDTH($bits(rlsc_pkg::stat_t)), .DEPTH(MAX_RECTS)) u_stat_ram (
    .clk(clk), .we(we_stat), .waddr(waddr_stat), .wdata(wstat),
    .raddr(raddr), .rdata(rstat)
  );

  rlsc_eval u_eval (.outer(outer), .inner(rrect), .cmp(cmp));

  assign p1_hit = (state == rlsc_pkg::FSM_INNER) && !pass2 && (i != j) &&
                  (outer_st == rlsc_pkg::ST_SANE) && (rstat.st == rlsc_pkg::ST_SANE) &&
                  cmp.same_scr && cmp.encl;
  assign p2_hit = (state == rlsc_pkg::FSM_INNER) && pass2 &&
                  (outer_st == rlsc_pkg::ST_SANE) && (rstat.st == rlsc_pkg::ST_SANE) &&
                  cmp.same_scr && cmp.ovl;
  assign offscr = (rrect.x < 0) || (rrect.y < 0) || (rrect.w <= 0) || (rrect.h <= 0) ||
                  (rrect.r >= rlsc_pkg::EDGE_LIMIT) || (rrect.b >= rlsc_pkg::EDGE_LIMIT);

  always_comb begin
    state_next = state;
    raddr      = i;
    we_rect    = 1'b0;
    we_stat    = 1'b0;
    waddr_stat = count[IW-1:0];
    wstat.st   = disabled_in ? rlsc_pkg::ST_DISABLED : rlsc_pkg::ST_SANE;
    wstat.enemy = 6'd0;
    unique case (state)
      rlsc_pkg::FSM_LOAD: begin
        we_rect = load_acc && has_room;
        we_stat = load_acc && has_room;
        if (load_acc && last_in) begin
          state_next = rlsc_pkg::FSM_RD_OUTER;
        end
      end
      rlsc_pkg::FSM_RD_OUTER: begin
        state_next = rlsc_pkg::FSM_LATCH;
      end
      rlsc_pkg::FSM_LATCH: begin
        raddr = '0;
        if (pass2 && (i == '0)) begin
          state_next = rlsc_pkg::FSM_NEXT_OUTER;
        end else begin
          state_next = rlsc_pkg::FSM_INNER;
        end
      end
      rlsc_pkg::FSM_INNER: begin
        raddr       = j + IW'(1);
        we_stat     = p1_hit;
        waddr_stat  = j;
        wstat.st    = cmp.dup ? rlsc_pkg::ST_DUPLICATE : rlsc_pkg::ST_ENCLOSED;
        wstat.enemy = 6'(i);
        if (inner_last) begin
          state_next = rlsc_pkg::FSM_NEXT_OUTER;
        end
      end
      rlsc_pkg::FSM_NEXT_OUTER: begin
        we_stat     = pass2 && ovl_hit;
        waddr_stat  = i;
        wstat.st    = rlsc_pkg::ST_OVERLAP;
        wstat.enemy = 6'(outer_en);
        if (outer_last && pass2) begin
          state_next = rlsc_pkg::FSM_EMIT_RD;
        end else begin
          state_next = rlsc_pkg::FSM_RD_OUTER;
        end
      end
      rlsc_pkg::FSM_EMIT_RD: begin
        state_next = rlsc_pkg::FSM_EMIT_WAIT;
      end
      rlsc_pkg::FSM_EMIT_WAIT: begin
        if (emit_take) begin
          state_next = outer_last ? rlsc_pkg::FSM_LOAD : rlsc_pkg::FSM_EMIT_RD;
        end
      end
      default: state_next = rlsc_pkg::FSM_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rlsc_pkg::FSM_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pass2     <= 1'b0;
      i         <= '0;
      j         <= '0;
      ovl_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_take) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rlsc_pkg::FSM_LOAD: begin
          if (load_acc && has_room) begin
            count <= count + CW'(1);
          end
          pass2 <= 1'b0;
          i     <= '0;
        end
        rlsc_pkg::FSM_LATCH: begin
          j       <= '0;
          ovl_hit <= 1'b0;
        end
        rlsc_pkg::FSM_INNER: begin
          j <= j + IW'(1);
          if (p2_hit) begin
            ovl_hit <= 1'b1;
          end
        end
        rlsc_pkg::FSM_NEXT_OUTER: begin
          if (outer_last) begin
            i     <= '0;
            pass2 <= 1'b1;
          end else begin
            i <= i + IW'(1);
          end
        end
        rlsc_pkg::FSM_EMIT_WAIT: begin
          if (emit_take) begin
            if (outer_last) begin
              count <= '0;
              i     <= '0;
            end else begin
              i <= i + IW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == rlsc_pkg::FSM_LATCH) begin
      outer    <= rrect;
      outer_st <= rstat.st;
    end
    if (p2_hit) begin
      outer_st <= rlsc_pkg::ST_OVERLAP;
      outer_en <= j;
    end
    if (emit_take) begin
      rect_index <= 6'(i);
      last_out   <= outer_last;
      if ((rstat.st == rlsc_pkg::ST_SANE) && offscr) begin
        status      <= rlsc_pkg::ST_OFFSCREEN;
        enemy_index <= 6'd0;
      end else begin
        status      <= rstat.st;
        enemy_index <= rstat.enemy;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RECTS))
    else $error("rectangle count exceeds capacity");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state != rlsc_pkg::FSM_LOAD) |-> (CW'(i) < count))
    else $error("outer index beyond loaded rectangles");

  a_enemy_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rlsc_pkg::ST_SANE || status == rlsc_pkg::ST_OFFSCREEN ||
    status == rlsc_pkg::ST_DISABLED) |-> (enemy_index == 6'd0))
    else $error("nonzero enemy index on a status without an enemy");

  a_no_self_enclose: assert property (@(posedge clk) disable iff (rst)
    p1_hit |-> (i != j))
    else $error("rectangle marked as enclosed by itself");
`endif

endmodule
`default_nettype wire
